// ===== sv/sisrl_pkg.sv =====
package sisrl_pkg;

  // Field widths of the channels and the configuration registers.
  localparam int RAND_W       = 32;
  localparam int SITE_COUNT_W = 13;
  localparam int THRESH_W     = 33;
  localparam int SITE_IDX_W   = 12;
  localparam int TOTAL_W      = 13;

  // Configuration port geometry: 64-bit data, registers at 8-byte strides.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  // Register index codes, taken from the top address bit.
  localparam logic REG_SITE_COUNT = 1'b0;
  localparam logic REG_RECOVERY   = 1'b1;

  localparam int MIN_SITES   = 3;
  localparam int RESET_SITES = 4096;

  // Neighbor window reload sequence and normal operation.
  typedef enum logic [1:0] {
    ST_FILL_LEFT,
    ST_FILL_CUR,
    ST_FILL_RIGHT,
    ST_RUN
  } fill_state_t;

  typedef struct packed {
    logic [SITE_IDX_W-1:0] site_index;
    logic                  site_active;
    logic [TOTAL_W-1:0]    active_total;
    logic                  sweep_end;
  } sisrl_result_t;

endpackage

// ===== sv/sisrl_sites.sv =====
module sisrl_sites #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/sisrl_outbuf.sv =====
module sisrl_outbuf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  sisrl_pkg::sisrl_result_t push_data,
  output logic                     full,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sisrl_pkg::sisrl_result_t out_data
);
  import sisrl_pkg::*;

  logic          main_vld_r, main_vld_nxt;
  logic          skid_vld_r, skid_vld_nxt;
  sisrl_result_t main_r, main_nxt;
  sisrl_result_t skid_r, skid_nxt;

  // The main slot drives the port; the skid slot catches a result produced
  // while the main slot is held by a stalled consumer.
  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (!main_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        main_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        main_vld_nxt = push;
        if (push) begin
          main_nxt = push_data;
        end
      end
    end else if (push) begin
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

endmodule

// ===== sv/sisrl_core.sv =====
module sisrl_core #(
  parameter int MAX_SITES = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [sisrl_pkg::RAND_W-1:0]        random_value,
  input  logic                                restart,
  output logic                                in_stall,
  input  logic [sisrl_pkg::SITE_COUNT_W-1:0]  site_count,
  input  logic [sisrl_pkg::THRESH_W-1:0]      recovery_threshold,
  input  logic                                resync,
  input  logic                                buf_full,
  output logic                                res_valid,
  output sisrl_pkg::sisrl_result_t            res
);
  import sisrl_pkg::*;

  localparam int AW     = $clog2(MAX_SITES);
  localparam int S_W    = $clog2(MAX_SITES + 1);
  localparam int SQ_W   = 2 * S_W;
  localparam int PROD_W = RAND_W + SQ_W;
  localparam int RST_S  = (MAX_SITES < RESET_SITES) ? MAX_SITES : RESET_SITES;

  fill_state_t     state_r, state_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [S_W-1:0]  fill_r, fill_nxt;
  logic [S_W-1:0]  cnt_r, cnt_nxt;
  logic [SQ_W-1:0] asq_r, asq_nxt;
  logic [SQ_W-1:0] ssq_r, ssq_nxt;
  logic            left_r, left_nxt;
  logic            cur_r, cur_nxt;
  logic            unw_r, unw_nxt;

  logic [S_W-1:0]    s;
  logic [AW-1:0]     p, p_next, right_next, left_addr;
  logic              last;
  logic              accept;
  logic              rd_en, wr_en, rd_bit;
  logic [AW-1:0]     rd_addr;
  logic              right_bit;
  logic [PROD_W-1:0] prod;
  logic [SQ_W:0]     rhs;
  logic              drop, fire, new_bit;
  logic [SQ_W-1:0]   twice_cnt;

  // Ring size in use, saturated into the supported range.
  always_comb begin
    if (site_count < SITE_COUNT_W'(MIN_SITES)) begin
      s = S_W'(MIN_SITES);
    end else if (32'(site_count) > 32'(MAX_SITES)) begin
      s = S_W'(MAX_SITES);
    end else begin
      s = S_W'(site_count);
    end
  end

  // A pointer left beyond a shrunken ring restarts at site 0.
  assign p          = (32'(ptr_r) >= 32'(s)) ? '0 : ptr_r;
  assign last       = (32'(p) + 32'd1 == 32'(s));
  assign p_next     = last ? '0 : p + AW'(1);
  assign right_next = (32'(p_next) + 32'd1 == 32'(s)) ? '0 : p_next + AW'(1);
  assign left_addr  = (p == '0) ? AW'(s - S_W'(1)) : p - AW'(1);

  assign in_stall  = (state_r != ST_RUN) || buf_full;
  assign accept    = in_valid && !in_stall;
  assign res_valid = accept;

  // Entries at or above the fill mark were not written since the last
  // restart and therefore read as active.
  assign right_bit = unw_r | rd_bit;

  assign prod = PROD_W'(random_value) * PROD_W'(ssq_r);

  always_comb begin
    if (left_r && right_bit) begin
      rhs = {asq_r, 1'b0};
    end else if (left_r || right_bit) begin
      rhs = {1'b0, asq_r};
    end else begin
      rhs = '0;
    end
  end

  assign fire      = (prod >> 31) < PROD_W'(rhs);
  assign drop      = {1'b0, random_value} < recovery_threshold;
  assign new_bit   = cur_r ? !drop : fire;
  assign twice_cnt = SQ_W'({cnt_r, 1'b0});

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    asq_nxt   = asq_r;
    left_nxt  = left_r;
    cur_nxt   = cur_r;
    unw_nxt   = unw_r;
    ssq_nxt   = SQ_W'(s) * SQ_W'(s);
    rd_en     = 1'b0;
    rd_addr   = p;
    wr_en     = 1'b0;

    res.site_index   = SITE_IDX_W'(p);
    res.site_active  = new_bit;
    res.active_total = '0;
    res.sweep_end    = last;

    unique case (state_r)
      ST_FILL_LEFT: begin
        rd_en     = 1'b1;
        rd_addr   = left_addr;
        state_nxt = ST_FILL_CUR;
      end
      ST_FILL_CUR: begin
        rd_en     = 1'b1;
        rd_addr   = p;
        left_nxt  = right_bit;
        state_nxt = ST_FILL_RIGHT;
      end
      ST_FILL_RIGHT: begin
        rd_en     = 1'b1;
        rd_addr   = p_next;
        cur_nxt   = right_bit;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (accept && restart) begin
          ptr_nxt  = '0;
          fill_nxt = '0;
          cnt_nxt  = s;
          asq_nxt  = ssq_r;
          left_nxt = 1'b1;
          cur_nxt  = 1'b1;
          unw_nxt  = 1'b1;
        end else if (accept) begin
          wr_en = 1'b1;
          if (cur_r && drop && (cnt_r != '0)) begin
            cnt_nxt = cnt_r - S_W'(1);
            asq_nxt = asq_r - twice_cnt + SQ_W'(1);
          end else if (!cur_r && fire && (32'(cnt_r) < 32'(MAX_SITES))) begin
            cnt_nxt = cnt_r + S_W'(1);
            asq_nxt = asq_r + twice_cnt + SQ_W'(1);
          end
          ptr_nxt = p_next;
          if (32'(p) + 32'd1 > 32'(fill_r)) begin
            fill_nxt = S_W'(32'(p) + 32'd1);
          end
          // Slide the window: the site just updated becomes the left
          // neighbor and the next site is fetched two ahead.
          left_nxt = new_bit;
          cur_nxt  = right_bit;
          rd_en    = 1'b1;
          rd_addr  = right_next;
        end
      end
      default: begin
        state_nxt = ST_FILL_LEFT;
      end
    endcase

    if (rd_en) begin
      unw_nxt = (32'(rd_addr) >= 32'(fill_r));
    end

    if (resync) begin
      state_nxt = ST_FILL_LEFT;
    end

    if (restart) begin
      res.site_index   = '0;
      res.site_active  = 1'b1;
      res.active_total = TOTAL_W'(s);
      res.sweep_end    = 1'b0;
    end else begin
      res.active_total = TOTAL_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      ptr_r   <= '0;
      fill_r  <= '0;
      cnt_r   <= S_W'(RST_S);
      asq_r   <= SQ_W'(RST_S * RST_S);
      ssq_r   <= SQ_W'(RST_S * RST_S);
      left_r  <= 1'b1;
      cur_r   <= 1'b1;
      unw_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      asq_r   <= asq_nxt;
      ssq_r   <= ssq_nxt;
      left_r  <= left_nxt;
      cur_r   <= cur_nxt;
      unw_r   <= unw_nxt;
    end
  end

  sisrl_sites #(
    .DEPTH (MAX_SITES),
    .AW    (AW)
  ) u_sites (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (p),
    .wr_data (new_bit),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bit)
  );

endmodule

// ===== sv/sis_ring_lattice_sweep.sv =====
// Each result is registered in the output buffer's main or skid slot.
// Throughput: one site update per cycle unless the input stalls; the site memory
// has one write and one read port, and the three neighbor bits are held in a
// sliding register window, reloaded on a site_count write while the input stalls.
// Reset (synchronous, rst_n low) makes every site active with no clearing pass.
module sis_ring_lattice_sweep #(
  parameter int MAX_SITES = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sisrl_pkg::RAND_W-1:0]        in_random_value,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sisrl_pkg::SITE_IDX_W-1:0]    out_site_index,
  output logic                                out_site_active,
  output logic [sisrl_pkg::TOTAL_W-1:0]       out_active_total,
  output logic                                out_sweep_end,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sisrl_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [sisrl_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [sisrl_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import sisrl_pkg::*;

  // Configuration registers. Registers sit at 8-byte strides, so the top
  // address bit selects between them.
  logic [SITE_COUNT_W-1:0] site_count_r, site_count_nxt;
  logic [THRESH_W-1:0]     thresh_r, thresh_nxt;
  logic                    reg_sel;
  logic                    cfg_wr;
  logic                    resync;

  logic          core_valid;
  sisrl_result_t core_res;
  sisrl_result_t out_res;
  logic          buf_full;

  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    site_count_nxt = site_count_r;
    thresh_nxt     = thresh_r;
    resync         = 1'b0;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_SITE_COUNT: begin
          site_count_nxt = SITE_COUNT_W'(pwdata);
          // A new ring size changes the neighbor relation, so the window
          // of cached neighbor states is reloaded.
          resync         = 1'b1;
        end
        REG_RECOVERY: begin
          thresh_nxt = THRESH_W'(pwdata);
        end
        default: begin
          resync = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SITE_COUNT: prdata = CFG_DATA_W'(site_count_r);
      REG_RECOVERY:   prdata = CFG_DATA_W'(thresh_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_count_r <= SITE_COUNT_W'(RESET_SITES);
      thresh_r     <= '0;
    end else begin
      site_count_r <= site_count_nxt;
      thresh_r     <= thresh_nxt;
    end
  end

  // The core updates one site per transfer. Each update reads the site and
  // its two ring neighbors from a register window, compares the random word
  // against either the recovery threshold or the infection bound, writes the
  // new state back and fetches the site two places ahead for the next update.
  sisrl_core #(
    .MAX_SITES (MAX_SITES)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .random_value       (in_random_value),
    .restart            (in_restart),
    .in_stall           (in_stall),
    .site_count         (site_count_r),
    .recovery_threshold (thresh_r),
    .resync             (resync),
    .buf_full           (buf_full),
    .res_valid          (core_valid),
    .res                (core_res)
  );

  // Two-entry output buffer: while a finished result waits on a stalled consumer,
  // one more result fits in the skid slot; once that is full the input stalls.
  sisrl_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (core_valid),
    .push_data (core_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_site_index   = out_res.site_index;
  assign out_site_active  = out_res.site_active;
  assign out_active_total = out_res.active_total;
  assign out_sweep_end    = out_res.sweep_end;

endmodule

// ===== tb/sis_ring_lattice_sweep_tb.sv =====
`timescale 1ns / 100ps

module sis_ring_lattice_sweep_tb;
  import sisrl_pkg::*;

  // The ring size the block is built with, and the bounds of the run.
  localparam int RING_MAX    = 4096;
  localparam int ITEM_TARGET = 1700;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 16;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid        = 1'b0;
  logic                    in_stall;
  logic [RAND_W-1:0]       in_random_value = '0;
  logic                    in_restart      = 1'b0;
  logic                    out_valid;
  logic                    out_stall       = 1'b0;
  logic [SITE_IDX_W-1:0]   out_site_index;
  logic                    out_site_active;
  logic [TOTAL_W-1:0]      out_active_total;
  logic                    out_sweep_end;
  logic                    psel            = 1'b0;
  logic                    penable         = 1'b0;
  logic                    pwrite          = 1'b0;
  logic [CFG_ADDR_W-1:0]   paddr           = '0;
  logic [CFG_DATA_W-1:0]   pwdata          = '0;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  sis_ring_lattice_sweep #(
    .MAX_SITES(RING_MAX)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_random_value  (in_random_value),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_site_index   (out_site_index),
    .out_site_active  (out_site_active),
    .out_active_total (out_active_total),
    .out_sweep_end    (out_sweep_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One random draw offered to the block: the uniform word and the restart flag.
  typedef struct {
    logic [RAND_W-1:0] word;
    logic              restart;
  } site_draw_t;

  site_draw_t    draw_queue[$];         // draws waiting to be offered
  sisrl_result_t predicted_updates[$];  // site updates predicted, oldest first

  int fail_count  = 0;
  int item_total  = 0;
  int quiet_count = 0;

  // Set by the sequencer: idle_en allows random gaps on both sides, hold_arm asks
  // the receiver for one long stall while the sender keeps offering.
  logic idle_en  = 1'b0;
  logic hold_arm = 1'b0;

  // Shadow of the configuration registers and of the ring, kept by the predictor.
  logic [SITE_COUNT_W-1:0] sites_reg  = SITE_COUNT_W'(RESET_SITES);
  logic [THRESH_W-1:0]     thresh_reg = '0;
  logic                    ring_state[RING_MAX];
  int                      ring_ptr;
  int                      ring_count;

  // Every mismatch counts as a failure and is reported.
  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  // The ring in use: the register value saturated into the legal range.
  function automatic int ring_size();
    if (sites_reg < SITE_COUNT_W'(MIN_SITES))
      return MIN_SITES;
    if (sites_reg > SITE_COUNT_W'(RING_MAX))
      return RING_MAX;
    return int'(sites_reg);
  endfunction

  function automatic void restart_ring();
    for (int i = 0; i < RING_MAX; i++)
      ring_state[i] = 1'b1;
    ring_ptr   = 0;
    ring_count = ring_size();
  endfunction

  // Predicts the result of one accepted draw and advances the shadow ring.
  function automatic sisrl_result_t update_site(input logic [RAND_W-1:0] word,
                                                input logic restart);
    sisrl_result_t res;
    int            s;
    int            p;
    int            lt;
    int            rt;
    int            nb;
    logic [63:0]   scale;
    logic [63:0]   lhs;
    logic [63:0]   rhs;
    s = ring_size();
    if (restart) begin
      restart_ring();
      res.site_index   = '0;
      res.site_active  = 1'b1;
      res.active_total = ring_count[TOTAL_W-1:0];
      res.sweep_end    = 1'b0;
      return res;
    end
    // A pointer left beyond a shrunken ring starts over at site zero.
    p  = (ring_ptr >= s) ? 0 : ring_ptr;
    lt = (p == 0) ? s - 1 : p - 1;
    rt = (p + 1 == s) ? 0 : p + 1;
    if (ring_state[p]) begin
      if ({1'b0, word} < thresh_reg) begin
        ring_state[p] = 1'b0;
        if (ring_count > 0)
          ring_count--;
      end
    end else begin
      // Infection test in exact integers: floor(u * 2S^2 / 2^32) < A^2 * n.
      nb    = int'(ring_state[lt]) + int'(ring_state[rt]);
      scale = 64'(2 * s * s);
      lhs   = ({32'd0, word} * scale) >> 32;
      rhs   = 64'(ring_count) * 64'(ring_count) * 64'(nb);
      if (lhs < rhs) begin
        ring_state[p] = 1'b1;
        if (ring_count < RING_MAX)
          ring_count++;
      end
    end
    ring_ptr         = (p + 1 == s) ? 0 : p + 1;
    res.site_index   = p[SITE_IDX_W-1:0];
    res.site_active  = ring_state[p];
    res.active_total = ring_count[TOTAL_W-1:0];
    res.sweep_end    = (p + 1 == s);
    return res;
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap(input int zero_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < zero_pct)
      return 0;
    if (roll < 93)
      return $urandom_range(1, 3);
    if (roll < 98)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Uniform words, with the two extreme values mixed in now and then.
  function automatic logic [RAND_W-1:0] rand_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)
      return '0;
    if (roll < 6)
      return '1;
    return $urandom;
  endfunction

  // Driver. A transfer happens at an edge where in_valid is high and in_stall is
  // low; the prediction is made right there, from the payload that was held.
  // The next draw is only loaded after a transfer or while valid is low, so a
  // stalled payload never changes.
  always @(posedge clk) begin : drv_proc
    logic       nxt_valid;
    int         gap;
    site_draw_t draw;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_random_value <= '0;
      in_restart      <= 1'b0;
      gap              = 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        predicted_updates.push_back(update_site(in_random_value, in_restart));
        nxt_valid = 1'b0;
        gap       = idle_en ? pick_gap(60) : 0;
      end
      if (!nxt_valid) begin
        if (gap > 0) begin
          gap--;
        end else if (draw_queue.size() != 0) begin
          draw             = draw_queue.pop_front();
          in_random_value <= draw.word;
          in_restart      <= draw.restart;
          nxt_valid        = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Monitor. Each result transfer is checked field by field against the oldest
  // prediction, then the stall for the next cycle is chosen. A requested long
  // hold is counted here, in the receiver's own process.
  always @(posedge clk) begin : mon_proc
    sisrl_result_t want;
    logic          nxt_stall;
    int            stall_left;
    int            hold_left;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left  = 0;
      hold_left   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_updates.size() == 0) begin
          fail_count++;
          $error("site update with none predicted: site_index %0d", out_site_index);
        end else begin
          want = predicted_updates.pop_front();
          check_field("site_index", want.site_index, out_site_index);
          check_field("site_active", want.site_active, out_site_active);
          check_field("active_total", want.active_total, out_active_total);
          check_field("sweep_end", want.sweep_end, out_sweep_end);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
        if (hold_left == 0)
          hold_arm = 1'b0;
      end else if (hold_arm) begin
        hold_left = HOLD_CYCLES;
        nxt_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (idle_en) begin
        stall_left = pick_gap(75);
        nxt_stall  = (stall_left > 0);
        if (nxt_stall)
          stall_left--;
      end else begin
        nxt_stall = 1'b0;
      end
      out_stall <= nxt_stall;
    end
  end

  // Watchdog: any transfer on either channel or the configuration port resets
  // the count of quiet cycles.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("sis_ring_lattice_sweep_tb NOT OK");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  task automatic push_draw(input logic [RAND_W-1:0] word, input logic restart);
    site_draw_t draw;
    draw.word    = word;
    draw.restart = restart;
    draw_queue.push_back(draw);
    item_total++;
  endtask

  // Waits, on falling edges where every posedge update has settled, until no
  // draw is pending or being offered and every predicted update has come out.
  task automatic wait_idle();
    do @(negedge clk);
    while (draw_queue.size() != 0 || in_valid || predicted_updates.size() != 0);
  endtask

  // Register write (setup, then access until pready) followed by a read back.
  // The shadow copy changes at the edge where the write lands; the block is
  // idle then, so no prediction is in progress.
  task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] stored;
    logic [CFG_DATA_W-1:0] rd;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 3'b000});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (idx == REG_SITE_COUNT) begin
      sites_reg = data[SITE_COUNT_W-1:0];
      stored    = CFG_DATA_W'(sites_reg);
    end else begin
      thresh_reg = data[THRESH_W-1:0];
      stored     = CFG_DATA_W'(thresh_reg);
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field((idx == REG_SITE_COUNT) ? "site_count readback" : "recovery_threshold readback",
                longint'(stored), longint'(rd));
    @(negedge clk);
  endtask

  // Sequencer: reset, a directed part, then random phases until enough draws.
  initial begin : seq_proc
    int                      phase_no;
    int                      roll;
    int                      len;
    logic [SITE_COUNT_W-1:0] sites;
    logic [THRESH_W-1:0]     thr;
    restart_ring();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Reset defaults: a full ring, no recovery. Word extremes leave sites active,
    // and a restart ignores its word.
    push_draw('0, 1'b0);
    push_draw('1, 1'b0);
    push_draw('1, 1'b1);
    wait_idle();

    // Smallest ring with certain recovery: the count runs down to zero, with the
    // sweep end on the third site.
    cfg_write(REG_RECOVERY, CFG_DATA_W'(33'h1_0000_0000));
    cfg_write(REG_SITE_COUNT, CFG_DATA_W'(3));
    push_draw($urandom, 1'b1);
    repeat (3) push_draw('1, 1'b0);
    wait_idle();

    // Growing the ring without a restart: the extra sites are still active and
    // their recovery drives the count against its floor of zero.
    cfg_write(REG_SITE_COUNT, CFG_DATA_W'(5));
    repeat (5) push_draw($urandom, 1'b0);
    wait_idle();

    // A site count below the minimum acts as three; half-way recovery odds.
    cfg_write(REG_SITE_COUNT, CFG_DATA_W'(0));
    cfg_write(REG_RECOVERY, CFG_DATA_W'(33'h0_8000_0000));
    push_draw($urandom, 1'b1);
    push_draw('0, 1'b0);
    push_draw('1, 1'b0);
    push_draw(32'h7FFF_FFFF, 1'b0);
    push_draw(32'h8000_0000, 1'b0);
    repeat (8) push_draw($urandom, 1'b0);
    wait_idle();

    // Shrinking the ring without a restart leaves the pointer past the end; it
    // has to wrap to site zero.
    cfg_write(REG_SITE_COUNT, CFG_DATA_W'(20));
    push_draw($urandom, 1'b1);
    repeat (15) push_draw($urandom, 1'b0);
    wait_idle();
    cfg_write(REG_SITE_COUNT, CFG_DATA_W'(10));
    repeat (4) push_draw($urandom, 1'b0);

    // Random phases. Most rings are small so that sweeps end often; a few are
    // at or beyond the largest size. Each phase starts only once the block has
    // drained, which also gives the sender-side pause.
    phase_no = 0;
    while (item_total < ITEM_TARGET) begin
      wait_idle();
      roll = $urandom_range(0, 99);
      if (roll < 70)
        sites = SITE_COUNT_W'($urandom_range(3, 16));
      else if (roll < 90)
        sites = SITE_COUNT_W'($urandom_range(17, 64));
      else if (roll < 97)
        sites = SITE_COUNT_W'($urandom_range(65, 300));
      else begin
        case ($urandom_range(0, 5))
          0:       sites = SITE_COUNT_W'(1);
          1:       sites = SITE_COUNT_W'(2);
          2:       sites = SITE_COUNT_W'(RING_MAX);
          3:       sites = SITE_COUNT_W'(5000);
          4:       sites = '1;
          default: sites = '0;
        endcase
      end
      roll = $urandom_range(0, 9);
      if (roll == 0)
        thr = '0;
      else if (roll == 1)
        thr = 33'h1_0000_0000;
      else if (roll < 4)
        thr = {1'b0, $urandom};
      else
        thr = {1'b0, 32'($urandom_range(0, 32'h6000_0000))};
      if (phase_no == 0 || $urandom_range(0, 3) != 0)
        cfg_write(REG_SITE_COUNT, CFG_DATA_W'(sites));
      if (phase_no == 0 || $urandom_range(0, 3) != 0)
        cfg_write(REG_RECOVERY, CFG_DATA_W'(thr));
      idle_en = ($urandom_range(0, 4) != 0);
      // One phase runs with the receiver holding off for a long time while the
      // sender offers back to back, so the block backs up into its input.
      if (phase_no == 3) begin
        idle_en  = 1'b0;
        hold_arm = 1'b1;
      end
      // Most phases restart; the others keep the ring through the new setting.
      if ($urandom_range(0, 6) != 0)
        push_draw($urandom, 1'b1);
      len = $urandom_range(30, 150);
      repeat (len) push_draw(rand_word(), ($urandom_range(0, 49) == 0));
      phase_no++;
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && predicted_updates.size() == 0) begin
      $display("sis_ring_lattice_sweep_tb OK");
    end else begin
      $display("sis_ring_lattice_sweep_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sisrl_pkg.sv
sv/sisrl_sites.sv
sv/sisrl_outbuf.sv
sv/sisrl_core.sv
sv/sis_ring_lattice_sweep.sv
tb/sis_ring_lattice_sweep_tb.sv
